@@ rtl/tensor_axis_reduce_defines.svh @@
// assertion macros shared by the rtl
`ifndef TENSOR_AXIS_REDUCE_DEFINES_SVH
`define TENSOR_AXIS_REDUCE_DEFINES_SVH

// condition holds at every clock edge outside reset
`define TAR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TAR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/tar_pkg.sv @@
package tar_pkg;

	localparam int ELEM_W    = 32;
	localparam int CFG_DW    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int INNER_W   = 11;
	localparam int AXIS_W    = 16;

	// queue depths between front and back, and behind the back end
	localparam int FRONT_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		OP_SUM  = 2'd0,
		OP_PROD = 2'd1,
		OP_MIN  = 2'd2,
		OP_MAX  = 2'd3
	} op_mode_t;

	typedef struct packed {
		logic first;
		logic last;
	} tar_tag_t;

endpackage

@@ rtl/tar_if.sv @@
interface tar_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [tar_pkg::ELEM_W-1:0]  element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface tar_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [tar_pkg::ELEM_W-1:0]  reduced_value;

	modport source (output valid, output reduced_value, input ready);
	modport sink   (input valid, input reduced_value, output ready);
endinterface

@@ rtl/tensor_axis_reduce.sv @@
// path: an element passes the item queue and stages s1 and s2; a result is pushed into the output queue
//   with the last element on its axis, and is offered from that queue
// throughput: one element per cycle while the output queue has credit left, set by the accumulator ram
//   doing one read and one write per cycle with the two newest writes forwarded; results stall only on the output side
// reset: arst_n clears counters, queues and pipeline valids, and sets op_mode 0, inner_size 1,
//   axis_length 1; accumulator ram is not cleared, every slot is seeded before use
module tensor_axis_reduce #(
	parameter int MAX_INNER = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tar_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tar_pkg::CFG_DW-1:0]     cfg_wdata,
	tar_in_if.sink                         feed,
	tar_out_if.source                      result
);

	import tar_pkg::*;

	localparam int SLOT_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int TAG_W  = $bits(tar_tag_t);
	localparam int QW     = ELEM_W + SLOT_W + TAG_W;

	// front side: counters place each element, tag marks first and last along the axis
	op_mode_t                  op_mode;
	logic                      f_valid;
	logic                      f_ready;
	logic signed [ELEM_W-1:0]  f_element;
	logic [SLOT_W-1:0]         f_slot;
	tar_tag_t                  f_tag;

	// back side: what the queue hands over
	logic                      b_valid;
	logic                      b_ready;
	logic [QW-1:0]             b_data;
	logic signed [ELEM_W-1:0]  b_element;
	logic [SLOT_W-1:0]         b_slot;
	tar_tag_t                  b_tag;

	tar_front #(
		.MAX_INNER (MAX_INNER)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.feed         (feed),
		.op_mode      (op_mode),
		.item_valid   (f_valid),
		.item_ready   (f_ready),
		.item_element (f_element),
		.item_slot    (f_slot),
		.item_tag     (f_tag)
	);

	// short queue decouples element intake from the accumulate pipeline
	tar_queue #(
		.WIDTH (QW),
		.DEPTH (FRONT_DEPTH)
	) u_item_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_element, f_slot, f_tag}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data),
		.level      ()
	);

	// unpack the queue entry
	assign b_element = b_data[QW-1 -: ELEM_W];
	assign b_slot    = b_data[TAG_W +: SLOT_W];
	assign b_tag     = tar_tag_t'(b_data[TAG_W-1:0]);

	// read, combine, write back; results gathered in an output queue
	tar_back #(
		.MAX_INNER (MAX_INNER)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_mode      (op_mode),
		.item_valid   (b_valid),
		.item_ready   (b_ready),
		.item_element (b_element),
		.item_slot    (b_slot),
		.item_tag     (b_tag),
		.result       (result)
	);

endmodule

@@ rtl/tar_ram.sv @@
module tar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tar_queue.sv @@
module tar_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data,
	output logic [LW-1:0]    level
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             push;
	logic             pop;

	assign push_ready = (level_q != LW'(DEPTH));
	assign pop_valid  = (level_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign level      = level_q;
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/tar_front.sv @@
`include "tensor_axis_reduce_defines.svh"

module tar_front #(
	parameter int MAX_INNER = 1024,
	localparam int SLOT_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tar_pkg::CFG_DW-1:0]         cfg_wdata,
	tar_in_if.sink                             feed,
	output tar_pkg::op_mode_t                  op_mode,
	output logic                               item_valid,
	input  logic                               item_ready,
	output logic signed [tar_pkg::ELEM_W-1:0]  item_element,
	output logic [SLOT_W-1:0]                  item_slot,
	output tar_pkg::tar_tag_t                  item_tag
);

	import tar_pkg::*;

	localparam int CNT_W = SLOT_W + 1;

	op_mode_t           op_mode_q;
	logic [INNER_W-1:0] inner_size_q;
	logic [AXIS_W-1:0]  axis_length_q;
	logic [SLOT_W-1:0]  inner_pos_q;
	logic [AXIS_W-1:0]  axis_pos_q;
	logic [CNT_W-1:0]   eff_inner;
	logic [AXIS_W-1:0]  eff_axis;
	logic               inner_wrap;
	logic               axis_last;
	logic               take;

	always_comb begin
		if (inner_size_q == '0) begin
			eff_inner = CNT_W'(1);
		end else if (32'(inner_size_q) > MAX_INNER) begin
			eff_inner = CNT_W'(MAX_INNER);
		end else begin
			eff_inner = CNT_W'(inner_size_q);
		end
		eff_axis   = (axis_length_q == '0) ? AXIS_W'(1) : axis_length_q;
		inner_wrap = (({1'b0, inner_pos_q} + CNT_W'(1)) == eff_inner);
		axis_last  = (({1'b0, axis_pos_q} + (AXIS_W + 1)'(1)) == {1'b0, eff_axis});
	end

	assign take          = feed.valid & item_ready;
	assign feed.ready    = item_ready;
	assign item_valid    = feed.valid;
	assign item_element  = feed.element;
	assign item_slot     = inner_pos_q;
	assign item_tag.first = (axis_pos_q == '0);
	assign item_tag.last  = axis_last;
	assign op_mode       = op_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q     <= OP_SUM;
			inner_size_q  <= INNER_W'(1);
			axis_length_q <= AXIS_W'(1);
			inner_pos_q   <= '0;
			axis_pos_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_OP_MODE: begin
					op_mode_q   <= op_mode_t'(cfg_wdata[1:0]);
					inner_pos_q <= '0;
					axis_pos_q  <= '0;
				end
				CFG_INNER_SIZE: begin
					inner_size_q <= cfg_wdata[INNER_W-1:0];
					inner_pos_q  <= '0;
					axis_pos_q   <= '0;
				end
				CFG_AXIS_LENGTH: begin
					axis_length_q <= cfg_wdata[AXIS_W-1:0];
					inner_pos_q   <= '0;
					axis_pos_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			if (inner_wrap) begin
				inner_pos_q <= '0;
				axis_pos_q  <= axis_last ? '0 : axis_pos_q + AXIS_W'(1);
			end else begin
				inner_pos_q <= inner_pos_q + SLOT_W'(1);
			end
		end
	end

	`TAR_ASSERT_ALWAYS(a_inner_in_range, clk, arst_n, {1'b0, inner_pos_q} < eff_inner, "inner position beyond inner size")
	`TAR_ASSERT_ALWAYS(a_axis_in_range, clk, arst_n, axis_pos_q < eff_axis, "axis position beyond axis length")

endmodule

@@ rtl/tar_back.sv @@
`include "tensor_axis_reduce_defines.svh"

module tar_back #(
	parameter int MAX_INNER = 1024,
	localparam int SLOT_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tar_pkg::op_mode_t                  op_mode,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [tar_pkg::ELEM_W-1:0]  item_element,
	input  logic [SLOT_W-1:0]                  item_slot,
	input  tar_pkg::tar_tag_t                  item_tag,
	tar_out_if.source                          result
);

	import tar_pkg::*;

	localparam int LW = $clog2(OUT_DEPTH + 1);
	localparam int CW = LW + 1;

	// stage 1: accumulator read data arrives
	logic                      valid_s1;
	logic signed [ELEM_W-1:0]  x_s1;
	logic [SLOT_W-1:0]         slot_s1;
	tar_tag_t                  tag_s1;
	logic [ELEM_W-1:0]         rdata;
	// stage 2: combined value, written back
	logic                      valid_s2;
	logic signed [ELEM_W-1:0]  v_s2;
	logic [SLOT_W-1:0]         slot_s2;
	logic                      last_s2;
	// stage 3: last write, still invisible to a read issued with it
	logic                      valid_s3;
	logic signed [ELEM_W-1:0]  v_s3;
	logic [SLOT_W-1:0]         slot_s3;

	logic signed [ELEM_W-1:0]  acc;
	logic signed [ELEM_W-1:0]  prod;
	logic signed [ELEM_W-1:0]  combined;
	logic signed [ELEM_W-1:0]  v_next;
	logic [LW-1:0]             out_level;
	logic [CW-1:0]             inflight;
	logic                      out_push_ready;
	logic [ELEM_W-1:0]         out_data;
	logic                      pop;

	// results in flight in stages s1 and s2, not yet pushed into the output queue
	assign inflight   = CW'(valid_s1 & tag_s1.last) + CW'(valid_s2 & last_s2);
	assign item_ready = (CW'(out_level) + inflight) < CW'(OUT_DEPTH);
	assign pop        = item_valid & item_ready;

	tar_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_INNER)
	) u_acc_ram (
		.clk   (clk),
		.we    (valid_s2),
		.waddr (slot_s2),
		.wdata (v_s2),
		.raddr (item_slot),
		.rdata (rdata)
	);

	always_comb begin
		priority if (valid_s2 && slot_s2 == slot_s1) begin
			acc = v_s2;
		end else if (valid_s3 && slot_s3 == slot_s1) begin
			acc = v_s3;
		end else begin
			acc = rdata;
		end
		prod = acc * x_s1;
		unique case (op_mode)
			OP_SUM:  combined = acc + x_s1;
			OP_PROD: combined = prod;
			OP_MIN:  combined = (acc < x_s1) ? acc : x_s1;
			OP_MAX:  combined = (acc < x_s1) ? x_s1 : acc;
			default: combined = acc;
		endcase
		v_next = tag_s1.first ? x_s1 : combined;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= item_element;
		slot_s1 <= item_slot;
		tag_s1  <= item_tag;
		v_s2    <= v_next;
		slot_s2 <= slot_s1;
		last_s2 <= tag_s1.last;
		v_s3    <= v_s2;
		slot_s3 <= slot_s2;
	end

	tar_queue #(
		.WIDTH (ELEM_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (valid_s2 & last_s2),
		.push_ready (out_push_ready),
		.push_data  (v_s2),
		.pop_valid  (result.valid),
		.pop_ready  (result.ready),
		.pop_data   (out_data),
		.level      (out_level)
	);

	assign result.reduced_value = out_data;

	`TAR_ASSERT_IMPL(a_out_room, clk, arst_n, valid_s2 && last_s2, out_push_ready, "result pushed into a full output queue")
	`TAR_ASSERT_ALWAYS(a_credit_bound, clk, arst_n, (CW'(out_level) + inflight) <= CW'(OUT_DEPTH), "output credit exceeded")

endmodule
